// File: src/bkvt_pkg.sv
// Shared types and constants of the byte key/value table.
// Used by bkvt_ctrl, bkvt_dp and byte_key_value_table_core.
`default_nettype none

package bkvt_pkg;

  // Default sizes of the table
  localparam int unsigned EntriesDef  = 32;
  localparam int unsigned ValueMaxDef = 4096;
  localparam int unsigned KeyMaxDef   = 64;

  // Fixed field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned VLEN_W   = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_KEY_BYTE   = 3'd0,
    CMD_SET        = 3'd1,
    CMD_VALUE_BYTE = 3'd2,
    CMD_GET        = 3'd3,
    CMD_READ_BYTE  = 3'd4,
    CMD_DELETE     = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_KEY_LONG     = 3'd2,
    ST_VALUE_LONG   = 3'd3,
    ST_FULL         = 3'd4,
    ST_NOTHING_OPEN = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_KEY_BYTE,
    OP_VALUE_BYTE,
    OP_READ_ISSUE,
    OP_REJECT,
    OP_START,
    OP_SLOT_RD,
    OP_SLOT_NEXT,
    OP_MATCH,
    OP_BYTE_RD,
    OP_BYTE_NEXT,
    OP_SET,
    OP_CP_RD,
    OP_CP_WR,
    OP_DELETE,
    OP_GET_RD,
    OP_GET_OPEN,
    OP_FINISH
  } dp_op_e;

  // Which extra fields a result carries
  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_GET,
    RES_READ
  } res_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SLOT,
    S_LEN,
    S_BYTE_RD,
    S_BYTE_CMP,
    S_RESOLVE,
    S_CP_RD,
    S_CP_WR,
    S_GET,
    S_FINISH
  } state_e;

  typedef struct packed {
    dp_op_e    op;
    logic      out_load;
    status_e   out_status;
    res_kind_e out_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic key_long;
    logic value_long;
    logic wr_open;
    logic rd_open;
    logic slot_match;
    logic slot_last;
    logic byte_eq;
    logic byte_last;
    logic zero_key;
    logic hit;
    logic free_found;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: src/byte_key_value_table_core.sv
// Byte key/value table, top level: joins controller and datapath.
// Depends on bkvt_pkg, bkvt_ctrl and bkvt_dp.
//
// Usage: each input item (command, data_byte, length) is taken at a rising
// edge with in_valid_i high and in_stall_o low; each gives exactly one
// result item (status, stored length, out_byte, last_byte), taken at an edge
// with out_valid_o high and out_stall_i low.
// Key byte, value byte and refused commands: the result is registered as
// the item is taken; a new item is taken every cycle while results drain.
// Read byte: the value memory read is registered, then moved to the result.
// Set, get and delete: the slot search reads each slot's key length and,
// on a match, each stored key byte through its memory port, a read step
// and a compare step per byte; set then copies the key, a read and a write
// step per byte, and get opens the read transfer from the stored length.
// The block holds in_stall_o high while an item is at work or the result
// register is full and stalled. Reset clears the used marks, the pending key
// and any open transfer at once; there is no clearing pass. A stalled
// result holds until taken.
`default_nettype none

module byte_key_value_table_core
  import bkvt_pkg::*;
#(
  parameter int unsigned ENTRIES   = EntriesDef,
  parameter int unsigned VALUE_MAX = ValueMaxDef,
  parameter int unsigned KEY_MAX   = KeyMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic [LEN_W-1:0]    length_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [VLEN_W-1:0]   vlen_o,
  output logic [BYTE_W-1:0]   out_byte_o,
  output logic                last_byte_o
);

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  bkvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  bkvt_dp #(
    .ENTRIES   (ENTRIES),
    .VALUE_MAX (VALUE_MAX),
    .KEY_MAX   (KEY_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .data_byte_i (data_byte_i),
    .length_i    (length_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .vlen_o      (vlen_o),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

`default_nettype wire

// File: src/bkvt_ctrl.sv
// Controller of the byte key/value table: sequences the slot search,
// key copy and transfers. Depends on bkvt_pkg.
`default_nettype none

module bkvt_ctrl
  import bkvt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  dp_stat_t            stat_i,
  output ctrl_cmd_t           ctrl_o
);

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  logic   in_fire;

  assign in_stall_o = (state_q != S_IDLE) || stat_i.out_busy;
  assign in_fire    = in_valid_i && !in_stall_o;

  // State and latched command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_KEY_BYTE;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d = cmd_e'(command_i);
          unique case (cmd_e'(command_i))
            CMD_READ_BYTE: if (stat_i.rd_open) state_d = S_READ;
            CMD_SET: if (!stat_i.value_long && !stat_i.key_long) state_d = S_SLOT;
            CMD_GET, CMD_DELETE: if (!stat_i.key_long) state_d = S_SLOT;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_READ: state_d = S_IDLE;
      S_SLOT: state_d = S_LEN;
      S_LEN: begin
        priority if (stat_i.slot_match && stat_i.zero_key) state_d = S_RESOLVE;
        else if (stat_i.slot_match) state_d = S_BYTE_RD;
        else if (stat_i.slot_last) state_d = S_RESOLVE;
        else state_d = S_SLOT;
      end
      S_BYTE_RD: state_d = S_BYTE_CMP;
      S_BYTE_CMP: begin
        priority if (!stat_i.byte_eq) state_d = stat_i.slot_last ? S_RESOLVE : S_SLOT;
        else if (stat_i.byte_last) state_d = S_RESOLVE;
        else state_d = S_BYTE_RD;
      end
      S_RESOLVE: begin
        unique case (cmd_q)
          CMD_SET: begin
            priority if (!(stat_i.hit || stat_i.free_found)) state_d = S_IDLE;
            else if (stat_i.zero_key) state_d = S_FINISH;
            else state_d = S_CP_RD;
          end
          CMD_GET: state_d = stat_i.hit ? S_GET : S_IDLE;
          default: state_d = S_IDLE;
        endcase
      end
      S_CP_RD: state_d = S_CP_WR;
      S_CP_WR: state_d = stat_i.byte_last ? S_FINISH : S_CP_RD;
      S_GET: state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctrl_o            = '0;
    ctrl_o.op         = OP_NONE;
    ctrl_o.out_status = ST_OK;
    ctrl_o.out_kind   = RES_PLAIN;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          ctrl_o.out_load = 1'b1;
          unique case (cmd_e'(command_i))
            CMD_KEY_BYTE: ctrl_o.op = OP_KEY_BYTE;
            CMD_VALUE_BYTE: begin
              if (stat_i.wr_open) ctrl_o.op = OP_VALUE_BYTE;
              else ctrl_o.out_status = ST_NOTHING_OPEN;
            end
            CMD_READ_BYTE: begin
              if (stat_i.rd_open) begin
                ctrl_o.op       = OP_READ_ISSUE;
                ctrl_o.out_load = 1'b0;
              end else begin
                ctrl_o.out_status = ST_NOTHING_OPEN;
              end
            end
            CMD_SET: begin
              priority if (stat_i.value_long) begin
                ctrl_o.op         = OP_REJECT;
                ctrl_o.out_status = ST_VALUE_LONG;
              end else if (stat_i.key_long) begin
                ctrl_o.op         = OP_REJECT;
                ctrl_o.out_status = ST_KEY_LONG;
              end else begin
                ctrl_o.op       = OP_START;
                ctrl_o.out_load = 1'b0;
              end
            end
            CMD_GET, CMD_DELETE: begin
              if (stat_i.key_long) begin
                ctrl_o.op         = OP_REJECT;
                ctrl_o.out_status = ST_KEY_LONG;
              end else begin
                ctrl_o.op       = OP_START;
                ctrl_o.out_load = 1'b0;
              end
            end
            default: ctrl_o.op = OP_NONE;
          endcase
        end
      end
      S_READ: begin
        ctrl_o.out_load = 1'b1;
        ctrl_o.out_kind = RES_READ;
      end
      S_SLOT: ctrl_o.op = OP_SLOT_RD;
      S_LEN: begin
        priority if (stat_i.slot_match && stat_i.zero_key) ctrl_o.op = OP_MATCH;
        else if (stat_i.slot_match) ctrl_o.op = OP_NONE;
        else ctrl_o.op = OP_SLOT_NEXT;
      end
      S_BYTE_RD: ctrl_o.op = OP_BYTE_RD;
      S_BYTE_CMP: begin
        priority if (!stat_i.byte_eq) ctrl_o.op = OP_SLOT_NEXT;
        else if (stat_i.byte_last) ctrl_o.op = OP_MATCH;
        else ctrl_o.op = OP_BYTE_NEXT;
      end
      S_RESOLVE: begin
        unique case (cmd_q)
          CMD_SET: begin
            if (stat_i.hit || stat_i.free_found) begin
              ctrl_o.op = OP_SET;
            end else begin
              ctrl_o.op         = OP_FINISH;
              ctrl_o.out_load   = 1'b1;
              ctrl_o.out_status = ST_FULL;
            end
          end
          CMD_GET: begin
            if (stat_i.hit) begin
              ctrl_o.op = OP_GET_RD;
            end else begin
              ctrl_o.op         = OP_FINISH;
              ctrl_o.out_load   = 1'b1;
              ctrl_o.out_status = ST_NOT_FOUND;
            end
          end
          default: begin
            ctrl_o.out_load = 1'b1;
            if (stat_i.hit) begin
              ctrl_o.op = OP_DELETE;
            end else begin
              ctrl_o.op         = OP_FINISH;
              ctrl_o.out_status = ST_NOT_FOUND;
            end
          end
        endcase
      end
      S_CP_RD: ctrl_o.op = OP_CP_RD;
      S_CP_WR: ctrl_o.op = OP_CP_WR;
      S_GET: ctrl_o.op = OP_GET_OPEN;
      S_FINISH: begin
        ctrl_o.op       = OP_FINISH;
        ctrl_o.out_load = 1'b1;
        ctrl_o.out_kind = (cmd_q == CMD_GET) ? RES_GET : RES_PLAIN;
      end
      default: ctrl_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: src/bkvt_dp.sv
// Datapath of the byte key/value table: pending key, slot stores, value
// memory, transfer pointers and the result register. Depends on bkvt_pkg.
`default_nettype none

module bkvt_dp
  import bkvt_pkg::*;
#(
  parameter int unsigned ENTRIES   = EntriesDef,
  parameter int unsigned VALUE_MAX = ValueMaxDef,
  parameter int unsigned KEY_MAX   = KeyMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           ctrl_i,
  output dp_stat_t            stat_o,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic [LEN_W-1:0]    length_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [VLEN_W-1:0]   vlen_o,
  output logic [BYTE_W-1:0]   out_byte_o,
  output logic                last_byte_o
);

  localparam int unsigned SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KLW = $clog2(KEY_MAX + 1);
  localparam int unsigned KIW = $clog2(KEY_MAX);
  localparam int unsigned LW  = $clog2(VALUE_MAX + 1);
  localparam int unsigned KD  = ENTRIES * KEY_MAX;
  localparam int unsigned VD  = ENTRIES * VALUE_MAX;
  localparam int unsigned KAW = $clog2(KD);
  localparam int unsigned VAW = (VD > 1) ? $clog2(VD) : 1;
  localparam int unsigned CW  = LEN_W + 1;

  // Stores
  logic [BYTE_W-1:0] pend_mem [KEY_MAX];
  logic [BYTE_W-1:0] key_mem  [KD];
  logic [KLW-1:0]    klen_mem [ENTRIES];
  logic [LW-1:0]     vlen_mem [ENTRIES];
  logic [BYTE_W-1:0] val_mem  [VD];

  logic [BYTE_W-1:0] pend_rd_q, key_rd_q, val_rd_q;
  logic [KLW-1:0]    klen_rd_q;
  logic [LW-1:0]     vlen_rd_q;

  // Control and working registers
  logic [ENTRIES-1:0] used_q;
  logic [KLW-1:0]     plen_q;
  logic               ended_q;
  mode_e              mode_q;
  logic [SW-1:0]      open_slot_q;
  logic [LW-1:0]      ptr_q, limit_q;
  logic [SW-1:0]      slot_q, hit_slot_q, free_slot_q, tgt_q;
  logic [KIW-1:0]     j_q;
  logic               hit_q, free_q;
  logic [LEN_W-1:0]   len_q;
  logic [LW-1:0]      res_vlen_q;
  logic               rd_last_q;

  logic                out_valid_q;
  status_e             status_q;
  logic [VLEN_W-1:0]   vlen_out_q;
  logic [BYTE_W-1:0]   byte_out_q;
  logic                last_out_q;

  logic [KLW-1:0] eff_len;
  logic           pend_we;
  logic [LW-1:0]  ptr_inc;
  logic           ptr_done;
  logic [VAW-1:0] val_addr;
  logic [KAW-1:0] key_raddr, key_waddr;
  logic [SW-1:0]  set_slot;
  logic [CW-1:0]  get_lim;
  logic           rd_open, wr_open;

  assign eff_len   = ended_q ? '0 : plen_q;
  assign pend_we   = (ctrl_i.op == OP_KEY_BYTE) && (data_byte_i != '0)
                     && (eff_len < KLW'(KEY_MAX));
  assign ptr_inc   = ptr_q + LW'(1);
  assign ptr_done  = ptr_inc >= limit_q;
  assign val_addr  = VAW'(open_slot_q) * VAW'(VALUE_MAX) + VAW'(ptr_q);
  assign key_raddr = KAW'(slot_q) * KAW'(KEY_MAX) + KAW'(j_q);
  assign key_waddr = KAW'(tgt_q) * KAW'(KEY_MAX) + KAW'(j_q);
  assign set_slot  = hit_q ? hit_slot_q : free_slot_q;
  assign get_lim   = (CW'(vlen_rd_q) < CW'(len_q)) ? CW'(vlen_rd_q) : CW'(len_q);
  assign wr_open   = (mode_q == MODE_WRITE) && (ptr_q < limit_q);
  assign rd_open   = (mode_q == MODE_READ) && (ptr_q < limit_q);

  // Status towards the controller
  always_comb begin
    stat_o.out_busy   = out_valid_q && out_stall_i;
    stat_o.key_long   = plen_q == KLW'(KEY_MAX);
    stat_o.value_long = CW'(length_i) > CW'(VALUE_MAX);
    stat_o.wr_open    = wr_open;
    stat_o.rd_open    = rd_open;
    stat_o.slot_match = used_q[slot_q] && (klen_rd_q == plen_q);
    stat_o.slot_last  = slot_q == SW'(ENTRIES - 1);
    stat_o.byte_eq    = key_rd_q == pend_rd_q;
    stat_o.byte_last  = (KLW'(j_q) + KLW'(1)) == plen_q;
    stat_o.zero_key   = plen_q == '0;
    stat_o.hit        = hit_q;
    stat_o.free_found = free_q;
  end

  // Pending key store
  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[KIW'(eff_len)] <= data_byte_i;
    pend_rd_q <= pend_mem[j_q];
  end

  // Slot key store
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_CP_WR) key_mem[key_waddr] <= pend_rd_q;
    key_rd_q <= key_mem[key_raddr];
  end

  // Slot length stores
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_SET) begin
      klen_mem[set_slot] <= plen_q;
      vlen_mem[set_slot] <= LW'(len_q);
    end
    klen_rd_q <= klen_mem[slot_q];
    vlen_rd_q <= vlen_mem[hit_slot_q];
  end

  // Value store
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_VALUE_BYTE) val_mem[val_addr] <= data_byte_i;
    if (ctrl_i.op == OP_READ_ISSUE) val_rd_q <= val_mem[val_addr];
  end

  // Table state and search registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      plen_q      <= '0;
      ended_q     <= 1'b0;
      mode_q      <= MODE_NONE;
      open_slot_q <= '0;
      ptr_q       <= '0;
      limit_q     <= '0;
      slot_q      <= '0;
      hit_slot_q  <= '0;
      free_slot_q <= '0;
      tgt_q       <= '0;
      j_q         <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      len_q       <= '0;
      res_vlen_q  <= '0;
      rd_last_q   <= 1'b0;
    end else begin
      unique case (ctrl_i.op)
        OP_KEY_BYTE: begin
          ended_q <= (data_byte_i == '0);
          plen_q  <= pend_we ? eff_len + KLW'(1) : eff_len;
        end
        OP_VALUE_BYTE: begin
          ptr_q <= ptr_inc;
          if (ptr_done) mode_q <= MODE_NONE;
        end
        OP_READ_ISSUE: begin
          ptr_q     <= ptr_inc;
          rd_last_q <= ptr_done;
          if (ptr_done) mode_q <= MODE_NONE;
        end
        OP_REJECT, OP_FINISH: begin
          mode_q  <= (ctrl_i.op == OP_REJECT) ? MODE_NONE : mode_q;
          plen_q  <= '0;
          ended_q <= 1'b0;
        end
        OP_START: begin
          mode_q <= MODE_NONE;
          slot_q <= '0;
          hit_q  <= 1'b0;
          free_q <= 1'b0;
          len_q  <= length_i;
        end
        OP_SLOT_RD: j_q <= '0;
        OP_SLOT_NEXT: begin
          if (!used_q[slot_q] && !free_q) begin
            free_q      <= 1'b1;
            free_slot_q <= slot_q;
          end
          slot_q <= slot_q + SW'(1);
        end
        OP_MATCH: begin
          hit_q      <= 1'b1;
          hit_slot_q <= slot_q;
        end
        OP_BYTE_NEXT, OP_CP_WR: j_q <= j_q + KIW'(1);
        OP_SET: begin
          tgt_q            <= set_slot;
          used_q[set_slot] <= 1'b1;
          open_slot_q      <= set_slot;
          ptr_q            <= '0;
          limit_q          <= LW'(len_q);
          mode_q           <= (len_q != '0) ? MODE_WRITE : MODE_NONE;
          j_q              <= '0;
        end
        OP_DELETE: begin
          used_q[hit_slot_q] <= 1'b0;
          plen_q             <= '0;
          ended_q            <= 1'b0;
        end
        OP_GET_OPEN: begin
          open_slot_q <= hit_slot_q;
          ptr_q       <= '0;
          limit_q     <= LW'(get_lim);
          mode_q      <= (get_lim != '0) ? MODE_READ : MODE_NONE;
          res_vlen_q  <= vlen_rd_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: load on command, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      vlen_out_q  <= '0;
      byte_out_q  <= '0;
      last_out_q  <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
      status_q    <= ctrl_i.out_status;
      vlen_out_q  <= (ctrl_i.out_kind == RES_GET) ? VLEN_W'(res_vlen_q) : '0;
      byte_out_q  <= (ctrl_i.out_kind == RES_READ) ? val_rd_q : '0;
      last_out_q  <= (ctrl_i.out_kind == RES_READ) ? rd_last_q : 1'b0;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign vlen_o      = vlen_out_q;
  assign out_byte_o  = byte_out_q;
  assign last_byte_o = last_out_q;

endmodule

`default_nettype wire

// File: verif/byte_key_value_table_tb.sv
// Self-checking testbench for byte_key_value_table_core.
// Depends on bkvt_pkg; it carries its own model of the table and checks each result item.
`default_nettype none

module tb;
  import bkvt_pkg::*;

  localparam int unsigned NSLOT  = EntriesDef;
  localparam int unsigned VMAX   = ValueMaxDef;
  localparam int unsigned KMAX   = KeyMaxDef;
  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned POOL   = 40;
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  typedef struct {
    status_e           st;
    logic [VLEN_W-1:0] vlen;
    logic [BYTE_W-1:0] obyte;
    logic              last;
  } table_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i = '0;
  logic [BYTE_W-1:0]   data_byte_i = '0;
  logic [LEN_W-1:0]    length_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [VLEN_W-1:0]   vlen_o;
  logic [BYTE_W-1:0]   out_byte_o;
  logic                last_byte_o;

  byte_key_value_table_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the table
  bit                used_sh [NSLOT];
  logic [BYTE_W-1:0] key_sh [NSLOT][KMAX];
  int unsigned       klen_sh [NSLOT];
  logic [BYTE_W-1:0] val_sh [NSLOT][VMAX];
  bit                written_sh [NSLOT][VMAX];
  int unsigned       vlen_sh [NSLOT];
  logic [BYTE_W-1:0] pend_key [KMAX];
  int unsigned       pend_len = 0;
  bit                pend_ended = 0;
  int unsigned       open_idx = 0;
  mode_e             open_md = MODE_NONE;
  int unsigned       xfer_ptr = 0;
  int unsigned       xfer_lim = 0;

  table_result_t expected_results[$];
  int unsigned   fail_count = 0;
  int unsigned   burst_left = 0;

  // Key pool for the random part
  logic [BYTE_W-1:0] pool_key [POOL][KMAX];
  int unsigned       pool_len [POOL];

  function automatic int find_slot();
    for (int i = 0; i < NSLOT; i++) begin
      if (used_sh[i] && klen_sh[i] == pend_len) begin
        bit same;
        same = 1;
        for (int j = 0; j < pend_len; j++) if (key_sh[i][j] != pend_key[j]) same = 0;
        if (same) return i;
      end
    end
    return -1;
  endfunction

  function automatic void open_xfer(int unsigned idx, mode_e md, int unsigned lim);
    open_idx = idx;
    xfer_ptr = 0;
    xfer_lim = lim;
    open_md  = (lim != 0) ? md : MODE_NONE;
  endfunction

  // Advance the shadow table by one item and return the result it gives
  function automatic table_result_t table_step(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] d,
                                               logic [LEN_W-1:0] len);
    table_result_t r;
    bit            klong;
    int            hit;
    bit            is_lookup;
    r = '{ST_OK, '0, '0, 1'b0};
    klong = pend_len >= KMAX;
    is_lookup = cmd inside {CMD_SET, CMD_GET, CMD_DELETE};
    if (is_lookup) open_md = MODE_NONE;
    case (cmd)
      CMD_KEY_BYTE: begin
        if (pend_ended) begin
          pend_len = 0;
          pend_ended = 0;
        end
        if (d == 0) pend_ended = 1;
        else if (pend_len < KMAX) begin
          pend_key[pend_len] = d;
          pend_len++;
        end
      end
      CMD_SET: begin
        if (len > VMAX) r.st = ST_VALUE_LONG;
        else if (klong) r.st = ST_KEY_LONG;
        else begin
          hit = find_slot();
          if (hit < 0)
            for (int i = NSLOT - 1; i >= 0; i--) if (!used_sh[i]) hit = i;
          if (hit < 0) r.st = ST_FULL;
          else begin
            used_sh[hit] = 1;
            klen_sh[hit] = pend_len;
            for (int j = 0; j < pend_len; j++) key_sh[hit][j] = pend_key[j];
            vlen_sh[hit] = len;
            open_xfer(hit, MODE_WRITE, len);
          end
        end
      end
      CMD_VALUE_BYTE: begin
        if (open_md == MODE_WRITE && xfer_ptr < xfer_lim) begin
          val_sh[open_idx][xfer_ptr] = d;
          written_sh[open_idx][xfer_ptr] = 1;
          xfer_ptr++;
          if (xfer_ptr >= xfer_lim) open_md = MODE_NONE;
        end else r.st = ST_NOTHING_OPEN;
      end
      CMD_GET: begin
        if (klong) r.st = ST_KEY_LONG;
        else begin
          hit = find_slot();
          if (hit < 0) r.st = ST_NOT_FOUND;
          else begin
            r.vlen = VLEN_W'(vlen_sh[hit]);
            open_xfer(hit, MODE_READ, vlen_sh[hit] < len ? vlen_sh[hit] : len);
          end
        end
      end
      CMD_READ_BYTE: begin
        if (open_md == MODE_READ && xfer_ptr < xfer_lim) begin
          r.obyte = val_sh[open_idx][xfer_ptr];
          xfer_ptr++;
          if (xfer_ptr >= xfer_lim) begin
            r.last = 1;
            open_md = MODE_NONE;
          end
        end else r.st = ST_NOTHING_OPEN;
      end
      CMD_DELETE: begin
        if (klong) r.st = ST_KEY_LONG;
        else begin
          hit = find_slot();
          if (hit < 0) r.st = ST_NOT_FOUND;
          else used_sh[hit] = 0;
        end
      end
      default: ;
    endcase
    if (is_lookup) begin
      pend_len = 0;
      pend_ended = 0;
    end
    return r;
  endfunction

  // True when a read byte item would touch a value byte never written
  function automatic bit read_unsafe();
    return open_md == MODE_READ && xfer_ptr < xfer_lim && !written_sh[open_idx][xfer_ptr];
  endfunction

  // Send one item; bursts of random length with random gaps between them
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] len);
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= d;
    length_i    <= len;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(table_step(cmd, d, len));
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end else burst_left--;
  endtask

  task automatic send_key(int unsigned n, logic [BYTE_W-1:0] seed, bit ended);
    for (int i = 0; i < n; i++) send_item(CMD_KEY_BYTE, seed + BYTE_W'(i), '0);
    if (ended) send_item(CMD_KEY_BYTE, 8'd0, '0);
  endtask

  task automatic send_pool_key(int unsigned k);
    for (int i = 0; i < pool_len[k]; i++) send_item(CMD_KEY_BYTE, pool_key[k][i], '0);
    if ($urandom_range(0, 3) != 0) send_item(CMD_KEY_BYTE, 8'd0, '0);
  endtask

  // Directed cases: basic set/get, refusals, zero transfers, key edge cases
  task automatic test_directed();
    send_key(1, 8'hA5, 1);
    send_item(CMD_SET, 8'h00, 16'd3);
    send_item(CMD_VALUE_BYTE, 8'h00, '0);
    send_item(CMD_VALUE_BYTE, 8'hFF, '0);
    send_item(CMD_VALUE_BYTE, 8'h5A, '0);
    send_item(CMD_VALUE_BYTE, 8'h11, '0);
    send_key(1, 8'hA5, 0);
    send_item(CMD_GET, 8'h00, 16'd2);
    send_item(CMD_READ_BYTE, '0, '0);
    send_item(CMD_READ_BYTE, '0, '0);
    send_item(CMD_READ_BYTE, '0, '0);
    send_item(CMD_SET, 8'h00, 16'd4097);
    send_key(KMAX, 8'h01, 1);
    send_item(CMD_GET, '0, 16'hFFFF);
    send_key(KMAX - 1, 8'h80, 1);
    send_item(CMD_SET, '0, 16'd0);
    send_key(KMAX - 1, 8'h80, 0);
    send_item(CMD_GET, '0, 16'd0);
    send_item(CMD_SET, '0, 16'hFFFF);
    send_item(CMD_DELETE, '0, '0);
    send_item(CMD_DELETE, '0, '0);
    send_item(CMD_SPARE_A, 8'hFF, 16'hFFFF);
    send_item(CMD_SPARE_B, 8'h00, 16'h0000);
  endtask

  // Fill the table, hit the full refusal, then delete the keys this test set
  task automatic test_full_table();
    for (int i = 0; i <= NSLOT; i++) begin
      send_key(2, BYTE_W'(8'h10 + 2 * i), 1);
      send_item(CMD_SET, '0, 16'd1);
      send_item(CMD_VALUE_BYTE, BYTE_W'(i), '0);
    end
    for (int i = 0; i < NSLOT; i++) begin
      send_key(2, BYTE_W'(8'h10 + 2 * i), 1);
      send_item(CMD_DELETE, '0, '0);
    end
  endtask

  // Random sequences over a pool of keys, with noise mixed in
  task automatic test_random(int unsigned n_items);
    int unsigned sent;
    int unsigned k, len, n;
    logic [CMD_W-1:0] c;
    sent = 0;
    for (int p = 0; p < POOL; p++) begin
      pool_len[p] = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 6);
      for (int j = 0; j < KMAX; j++) pool_key[p][j] = BYTE_W'($urandom_range(1, 255));
    end
    while (sent < n_items) begin
      k = $urandom_range(0, POOL - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_pool_key(k);
          case ($urandom_range(0, 19))
            0:       len = $urandom_range(0, 65535);
            1:       len = $urandom_range(VMAX - 2, VMAX + 2);
            default: len = $urandom_range(0, 10);
          endcase
          send_item(CMD_SET, '0, LEN_W'(len));
          n = (len > 16) ? $urandom_range(0, 4) : len + $urandom_range(0, 1);
          if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);
          for (int i = 0; i < n; i++) send_item(CMD_VALUE_BYTE, BYTE_W'($urandom), '0);
          sent += pool_len[k] + n + 2;
        end
        4, 5, 6: begin
          send_pool_key(k);
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
          send_item(CMD_GET, BYTE_W'($urandom), LEN_W'(len));
          n = $urandom_range(0, 12);
          for (int i = 0; i < n && !read_unsafe(); i++) send_item(CMD_READ_BYTE, '0, '0);
          sent += pool_len[k] + n + 2;
        end
        7: begin
          send_pool_key(k);
          send_item(CMD_DELETE, '0, LEN_W'($urandom));
          sent += pool_len[k] + 2;
        end
        default: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            c = CMD_W'($urandom_range(0, 7));
            if (c == CMD_READ_BYTE && read_unsafe()) c = CMD_SPARE_A;
            send_item(c, BYTE_W'($urandom), LEN_W'($urandom));
          end
          sent += n;
        end
      endcase
    end
  endtask

  // Check each result item against the oldest expectation
  always @(posedge clk_i) begin
    table_result_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d", $time, status_o);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (status_o !== e.st || vlen_o !== e.vlen || out_byte_o !== e.obyte ||
            last_byte_o !== e.last) begin
          $display("%0t: mismatch expected st=%0d vlen=%0d byte=%0h last=%0b", $time,
                   e.st, e.vlen, e.obyte, e.last);
          $display("%0t:          actual   st=%0d vlen=%0d byte=%0h last=%0b", $time,
                   status_o, vlen_o, out_byte_o, last_byte_o);
          fail_count++;
        end
      end
    end
  end

  // Stall the result side on a pattern of changing phases
  int unsigned stall_phase = 0;
  int unsigned phase_left = 0;
  always @(posedge clk_i) begin
    if (phase_left == 0) begin
      stall_phase <= $urandom_range(0, 3);
      phase_left  <= $urandom_range(20, 200);
    end else phase_left <= phase_left - 1;
    case (stall_phase)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 1) == 0);
      2:       out_stall_i <= ($urandom_range(0, 7) != 0);
      default: out_stall_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog: end the run after too long with nothing accepted
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random(750);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
